// ===== rtl/ppbe_pkg.sv =====
// ppbe_pkg: shared constants and types of the packed pixel blend engine.
// Used by ppbe_store and packed_pixel_blend_engine; depends on nothing.
package ppbe_pkg;

    // store geometry
    localparam int unsigned STORE_BYTES = 65536;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

    // coordinate and stride geometry
    localparam int unsigned COORD_BITS  = 12;
    localparam int unsigned STRIDE_W    = 12;
    localparam int unsigned PROD_W      = COORD_BITS + STRIDE_W;
    localparam int unsigned LIN_W       = (PROD_W + 1 > ADDR_W + 1) ? PROD_W + 1 : ADDR_W + 1;

    // configuration port
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER = 2'd2;

    // pixel formats
    localparam logic [2:0] FMT_MONO_VLSB = 3'd0;
    localparam logic [2:0] FMT_MONO_HLSB = 3'd1;
    localparam logic [2:0] FMT_MONO_HMSB = 3'd2;
    localparam logic [2:0] FMT_GREY2     = 3'd3;
    localparam logic [2:0] FMT_GREY4     = 3'd4;
    localparam logic [2:0] FMT_GREY8     = 3'd5;
    localparam logic [2:0] FMT_NONE      = 3'd6;

    // actions; the last code is reserved and does nothing
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_BLEND  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // reciprocals for divide-by-multiply: ceil(2^24 / d)
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_255 = ((1 << RECIP_SHIFT) + 254) / 255;
    localparam int unsigned RECIP_85  = ((1 << RECIP_SHIFT) + 84) / 85;
    localparam int unsigned RECIP_17  = ((1 << RECIP_SHIFT) + 16) / 17;

    // dither step and mono threshold
    localparam int DITHER_STEP    = 42;
    localparam int MONO_THRESHOLD = 127;

    // single-port store request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage

// ===== rtl/ppbe_store.sv =====
// ppbe_store: byte-wide frame store, one access per cycle, registered read data.
// Depends on ppbe_pkg (t_mem_req, STORE_BYTES).
module ppbe_store (
    input  logic              i_clk,
    input  ppbe_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import ppbe_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    // write port and read-before-write data register
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/packed_pixel_blend_engine.sv =====
// packed_pixel_blend_engine: pixel read/write/blend over a packed byte frame store.
// Depends on ppbe_pkg and ppbe_store.
//
//   channel   signals                                          direction
//   command   start, busy, i_action, i_x_coord, i_y_coord,     in, busy out
//             i_color, i_alpha
//   result    o_valid, o_read_value, o_out_of_range            out
//   config    i_cfg_we, i_cfg_idx, i_cfg_wdata                 in
//
// A command is taken when start is high and busy is low; one command is in flight at a time.
// Normal access: accept, then address multiply, store read, mix multiply, reciprocal
// multiply, quantize multiply and write back, then the result strobe; a new command
// may be taken in the strobe cycle. Out-of-store access goes from the store address
// to write back; format none or unused action from the address multiply to write back.
// After reset a clearing pass writes zero to all STORE_BYTES (65536) bytes, one per
// cycle, with busy high; config writes are taken meanwhile. Results cannot be stalled.
module packed_pixel_blend_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic [ppbe_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic [ppbe_pkg::COORD_BITS-1:0] i_y_coord,
    input  logic [7:0]                      i_color,
    input  logic [7:0]                      i_alpha,
    output logic                            o_valid,
    output logic [7:0]                      o_read_value,
    output logic                            o_out_of_range,
    input  logic                            i_cfg_we,
    input  logic [ppbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppbe_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ppbe_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ADDR, S_DATA, S_MIX, S_SUM, S_QNT, S_WB
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [2:0]          r_fmt;
    logic [STRIDE_W-1:0] r_stride;
    logic [3:0]          r_dither;

    // transaction payload
    logic [1:0]            r_act;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [7:0]            r_color, r_alpha;
    logic                  r_nop, r_oor;
    logic [PROD_W-1:0]     r_prod;
    logic [ADDR_W-1:0]     r_addr;
    logic [2:0]            r_shift;
    logic [7:0]            r_byte, r_level;
    logic [15:0]           r_ca, r_da;
    logic [7:0]            r_mixv, r_field;
    logic                  r_bit;
    logic [ADDR_W-1:0]     r_clr;

    // registered result
    logic       r_valid;
    logic [7:0] r_rd_val;
    logic       r_rd_oor;

    // store
    t_mem_req   w_req;
    logic [7:0] w_rdata;

    logic w_accept;
    logic w_mono;
    logic [7:0] w_fmask;
    assign w_accept = start && (r_state == S_IDLE);
    assign w_mono   = (r_fmt == FMT_MONO_VLSB) || (r_fmt == FMT_MONO_HLSB)
                   || (r_fmt == FMT_MONO_HMSB);

    always_comb begin
        case (r_fmt)
            FMT_GREY2: w_fmask = 8'h03;
            FMT_GREY4: w_fmask = 8'h0f;
            FMT_GREY8: w_fmask = 8'hff;
            default:   w_fmask = 8'h01;
        endcase
    end

    // address multiply operand: vlsb packs 8 rows per byte row
    logic [COORD_BITS-1:0] w_ymul;
    assign w_ymul = (r_fmt == FMT_MONO_VLSB) ? (r_y >> 3) : r_y;

    // linear and byte address
    logic [LIN_W-1:0] w_lin, w_baddr;
    logic             w_oor;
    logic [2:0]       w_shift;
    assign w_lin = LIN_W'(r_x) + LIN_W'(r_prod);
    always_comb begin
        case (r_fmt)
            FMT_MONO_VLSB: begin w_baddr = w_lin;      w_shift = r_y[2:0]; end
            FMT_MONO_HLSB: begin w_baddr = w_lin >> 3; w_shift = ~r_x[2:0]; end
            FMT_MONO_HMSB: begin w_baddr = w_lin >> 3; w_shift = r_x[2:0]; end
            FMT_GREY2:     begin w_baddr = w_lin >> 2; w_shift = {r_x[1:0], 1'b0}; end
            FMT_GREY4:     begin w_baddr = w_lin >> 1; w_shift = r_x[0] ? 3'd0 : 3'd4; end
            default:       begin w_baddr = w_lin;      w_shift = 3'd0; end
        endcase
    end
    assign w_oor = w_baddr >= LIN_W'(STORE_BYTES);

    // field extraction and normalized level
    logic [7:0] w_field, w_level;
    assign w_field = (w_rdata >> r_shift) & w_fmask;
    always_comb begin
        case (r_fmt)
            FMT_GREY2: w_level = 8'(16'(w_field) * 16'd85);
            FMT_GREY4: w_level = 8'(16'(w_field) * 16'd17);
            FMT_GREY8: w_level = w_field;
            default:   w_level = (w_field != 8'd0) ? 8'hff : 8'h00;
        endcase
    end

    // mix: (c*a + dst*(255-a)) / 255 by reciprocal
    logic [16:0] w_sum;
    logic [33:0] w_mixp;
    assign w_sum  = 17'(r_ca) + 17'(r_da);
    assign w_mixp = 34'(w_sum) * 34'(RECIP_255);

    // quantize to field width
    logic [7:0]  w_v;
    logic [31:0] w_qp;
    logic [7:0]  w_qfield;
    assign w_v = (r_act == ACT_BLEND && r_alpha != 8'hff) ? r_mixv : r_color;
    always_comb begin
        case (r_fmt)
            FMT_GREY2: w_qp = 32'(w_v) * 32'(RECIP_85);
            FMT_GREY4: w_qp = 32'(w_v) * 32'(RECIP_17);
            default:   w_qp = {w_v, 24'd0};
        endcase
    end
    assign w_qfield = w_qp[31:24] & w_fmask;

    // mono dither: color +/- strength*42, unclamped
    logic signed [11:0] w_doff, w_dv;
    logic               w_mono_on;
    assign w_doff    = 12'($signed({1'b0, r_dither}) * 12'sd42);
    assign w_dv      = (r_x[0] ^ r_y[0]) ? ($signed({4'd0, r_color}) + w_doff)
                                         : ($signed({4'd0, r_color}) - w_doff);
    assign w_mono_on = w_dv > 12'(MONO_THRESHOLD);

    // write-back decision and new byte
    logic       w_do_write;
    logic [7:0] w_bitm, w_new;
    always_comb begin
        w_do_write = 1'b0;
        if (!r_nop && !r_oor && r_act != ACT_READ) begin
            if (w_mono) begin
                w_do_write = (r_act == ACT_WRITE) || (r_alpha > 8'd127);
            end else begin
                w_do_write = (r_act == ACT_WRITE) || (r_alpha != 8'd0);
            end
        end
    end
    assign w_bitm = 8'h01 << r_shift;
    always_comb begin
        if (w_mono) begin
            w_new = r_bit ? (r_byte | w_bitm) : (r_byte & ~w_bitm);
        end else begin
            w_new = (r_byte & ~(w_fmask << r_shift)) | (r_field << r_shift);
        end
    end

    // store port: clear sweep, read in address cycle, write back at the end
    always_comb begin
        w_req.we    = 1'b0;
        w_req.addr  = r_addr;
        w_req.wdata = w_new;
        unique case (r_state)
            S_CLEAR: begin
                w_req.we    = 1'b1;
                w_req.addr  = r_clr;
                w_req.wdata = 8'h00;
            end
            S_ADDR:  w_req.addr = w_baddr[ADDR_W-1:0];
            S_WB:    w_req.we = w_do_write;
            default: ;
        endcase
    end

    ppbe_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ADDR_W'(STORE_BYTES - 1)) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_MUL;
            S_MUL:   n_state = r_nop ? S_WB : S_ADDR;
            S_ADDR:  n_state = w_oor ? S_WB : S_DATA;
            S_DATA:  n_state = S_MIX;
            S_MIX:   n_state = S_SUM;
            S_SUM:   n_state = S_QNT;
            S_QNT:   n_state = S_WB;
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state, configuration, payload and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_fmt    <= FMT_NONE;
            r_stride <= '0;
            r_dither <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_WB);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FORMAT: r_fmt    <= i_cfg_wdata[2:0];
                    REG_STRIDE: r_stride <= i_cfg_wdata[STRIDE_W-1:0];
                    REG_DITHER: r_dither <= i_cfg_wdata[3:0];
                    default:    ;
                endcase
            end
        end

        // payload, no reset
        if (w_accept) begin
            r_act   <= i_action;
            r_x     <= i_x_coord;
            r_y     <= i_y_coord;
            r_color <= i_color;
            r_alpha <= i_alpha;
            r_nop   <= (i_action == ACT_UNUSED) || (r_fmt > FMT_GREY8);
            r_oor   <= 1'b0;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(w_ymul) * PROD_W'(r_stride);
        end
        if (r_state == S_ADDR) begin
            r_addr  <= w_baddr[ADDR_W-1:0];
            r_oor   <= w_oor;
            r_shift <= w_shift;
        end
        if (r_state == S_DATA) begin
            r_byte  <= w_rdata;
            r_level <= w_level;
        end
        if (r_state == S_MIX) begin
            r_ca <= 16'(r_color) * 16'(r_alpha);
            r_da <= 16'(r_level) * 16'(8'hff - r_alpha);
        end
        if (r_state == S_SUM) begin
            r_mixv <= w_mixp[31:24];
        end
        if (r_state == S_QNT) begin
            r_field <= w_qfield;
            r_bit   <= w_mono_on;
        end
        if (r_state == S_WB) begin
            r_rd_oor <= r_oor && !r_nop;
            r_rd_val <= (!r_nop && !r_oor && r_act == ACT_READ) ? r_level : 8'h00;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_read_value   = r_rd_val;
    assign o_out_of_range = r_rd_oor;

endmodule

// ===== rtl/ppbe_checker.sv =====
// ppbe_checker: port-level assertions for packed_pixel_blend_engine, with its bind.
// Depends on ppbe_pkg only through the bound top level.
module ppbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [7:0] o_read_value,
    input logic       o_out_of_range
);

    // a result appears only once the engine has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction makes the engine busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but busy stayed low");

    // one transaction in flight, so strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result strobes in a row");

    // out-of-store access never reports a level
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_read_value == 8'h00))
        else $error("nonzero read value with out-of-store flag");

    // a strobe follows a busy cycle
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result strobe without preceding work");

endmodule

bind packed_pixel_blend_engine ppbe_checker u_ppbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_read_value   (o_read_value),
    .o_out_of_range (o_out_of_range)
);
